/* src/wtb_pkg.sv */
// Shared constants, types and the quarter-wave sine table of the tone burst generator.
package wtb_pkg;

  localparam int unsigned SINE_TABLE_DEPTH = 256;
  localparam int unsigned SAMPLE_WIDTH     = 16;

  localparam int unsigned IdxW       = $clog2(SINE_TABLE_DEPTH) + 1;
  localparam int unsigned RomW       = SAMPLE_WIDTH - 1;
  localparam int unsigned ProdW      = 2 * RomW;
  localparam int unsigned AmpW       = 15;
  localparam int unsigned MagW       = ProdW + AmpW;
  localparam int unsigned RoundShift = 2 * SAMPLE_WIDTH - 2;
  localparam int unsigned OutW       = 16;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 32;

  localparam logic [RomW-1:0] FullScale  = {RomW{1'b1}};
  localparam logic [63:0]     PiHalfQ30  = 64'd1686629713;
  localparam logic [63:0]     Q30One     = 64'd1 << 30;
  localparam logic [63:0]     Q30Half    = 64'd1 << 29;
  localparam logic [MagW:0]   RoundHalf  = (MagW + 1)'(1) << (RoundShift - 1);
  localparam logic [OutW-1:0] Ceiling    = 16'd16384;
  localparam logic [31:0]     QuarterTurn = 32'h4000_0000;

  // Register indexes of the configuration port.
  typedef enum logic [CfgIdxW-1:0] {
    CfgLeadIn   = 3'd0,
    CfgSpacing  = 3'd1,
    CfgBurstLen = 3'd2,
    CfgBurstCnt = 3'd3,
    CfgToneStep = 3'd4,
    CfgWinStep  = 3'd5,
    CfgAmp      = 3'd6,
    CfgWatchdog = 3'd7
  } cfg_idx_e;

  typedef enum logic [7:0] {
    StIdle   = 8'b0000_0001,
    StStart  = 8'b0000_0010,
    StCmp    = 8'b0000_0100,
    StPhase  = 8'b0000_1000,
    StLookup = 8'b0001_0000,
    StMul1   = 8'b0010_0000,
    StMul2   = 8'b0100_0000,
    StFinish = 8'b1000_0000
  } state_e;

  typedef struct packed {
    logic accept;
    logic start;
    logic cmp;
    logic phase;
    logic lookup;
    logic mul1;
    logic mul2;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic in_burst;
  } sts_t;

  typedef logic [SINE_TABLE_DEPTH:0][RomW-1:0] rom_t;

  // One odd power step of the Q2.30 Taylor series: t * a^2.
  function automatic logic [63:0] taylor_pow(input logic [63:0] t, input logic [63:0] a);
    return (((t * a) >> 30) * a) >> 30;
  endfunction

  function automatic logic [RomW-1:0] sine_entry(input int unsigned k);
    logic [63:0]        a;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        v;
    a    = (PiHalfQ30 * 64'(k)) / 64'(SINE_TABLE_DEPTH);
    term = a;
    sum  = signed'(a);
    term = taylor_pow(term, a) / 64'd6;
    sum  = sum - signed'(term);
    term = taylor_pow(term, a) / 64'd20;
    sum  = sum + signed'(term);
    term = taylor_pow(term, a) / 64'd42;
    sum  = sum - signed'(term);
    term = taylor_pow(term, a) / 64'd72;
    sum  = sum + signed'(term);
    term = taylor_pow(term, a) / 64'd110;
    sum  = sum - signed'(term);
    term = taylor_pow(term, a) / 64'd156;
    sum  = sum + signed'(term);
    term = taylor_pow(term, a) / 64'd210;
    sum  = sum - signed'(term);
    if (sum < 64'sd0) sum = 64'sd0;
    if (sum > signed'(Q30One)) sum = signed'(Q30One);
    v = (64'(sum) * 64'(FullScale) + Q30Half) >> 30;
    if (v > 64'(FullScale)) v = 64'(FullScale);
    return v[RomW-1:0];
  endfunction

  function automatic rom_t build_rom();
    rom_t r;
    for (int unsigned k = 0; k <= SINE_TABLE_DEPTH; k++) begin
      r[k] = sine_entry(k);
    end
    return r;
  endfunction

  localparam rom_t SineRom = build_rom();

  function automatic logic [IdxW-1:0] rom_index(input logic [31:0] ph);
    logic [63:0] p;
    p = 64'(ph[29:0]) * 64'(SINE_TABLE_DEPTH);
    return IdxW'(p >> 30);
  endfunction

  // Magnitude of the sine of a 32-bit phase; the sign is phase bit 31.
  function automatic logic [RomW-1:0] sine_mag(input logic [31:0] ph);
    logic [IdxW-1:0] idx;
    idx = rom_index(ph);
    if (ph[30]) begin
      return SineRom[IdxW'(SINE_TABLE_DEPTH) - idx];
    end
    return SineRom[idx];
  endfunction

endpackage

/* src/windowed_tone_burst_generator.sv */
// Top level of the Hann-windowed tone burst generator.
//
// Each transfer on the input channel is one audio frame tick carrying a flag
// that marks the frame's input sample as invalid. For every input transfer the
// block delivers exactly one output transfer: a Q1.15 sample within +-0.5 and
// the mute, in-burst, burst-end and completed-burst status of that frame.
// Configuration registers are written through cfg_we_i, cfg_index_i and
// cfg_data_i, one register per write, while no frame is in flight.
//
// Frames are processed one at a time by a state machine that steps a shared
// datapath. For a frame inside a burst the result is registered through the
// offset multiply, start add, compare, phase multiply, table lookup, two product
// stages, then rounding into the output register; a frame outside a burst skips
// the lookup and products. The next frame is accepted in the cycle after the
// result is loaded.
//
// The result sits in an output register, so a new frame is accepted and
// worked on while the previous result waits; if the receiver still stalls
// when the next result is ready, the block holds in its final step.
// Reset restores the register defaults and clears the frame counter, the
// mute flag and the burst count; no output transfer is pending after reset.
module windowed_tone_burst_generator import wtb_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                sample_invalid_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [OutW-1:0]     out_sample_o,
  output logic                is_muted_o,
  output logic                in_burst_o,
  output logic                burst_end_o,
  output logic [7:0]          bursts_emitted_o
);

  cmd_t cmd;
  sts_t sts;

  wtb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  wtb_dpath u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .sample_invalid_i (sample_invalid_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_sample_o     (out_sample_o),
    .is_muted_o       (is_muted_o),
    .in_burst_o       (in_burst_o),
    .burst_end_o      (burst_end_o),
    .bursts_emitted_o (bursts_emitted_o)
  );

endmodule

/* src/wtb_ctrl.sv */
// Sequencing state machine and handshake control of the tone burst generator.
module wtb_ctrl import wtb_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q & ~out_ready_i;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = StStart;
        end
      end
      StStart: begin
        cmd_o.start = 1'b1;
        state_d     = StCmp;
      end
      StCmp: begin
        cmd_o.cmp = 1'b1;
        state_d   = StPhase;
      end
      StPhase: begin
        cmd_o.phase = 1'b1;
        // Frames outside a burst need no table lookup or multiply.
        state_d     = sts_i.in_burst ? StLookup : StFinish;
      end
      StLookup: begin
        cmd_o.lookup = 1'b1;
        state_d      = StMul1;
      end
      StMul1: begin
        cmd_o.mul1 = 1'b1;
        state_d    = StMul2;
      end
      StMul2: begin
        cmd_o.mul2 = 1'b1;
        state_d    = StFinish;
      end
      StFinish: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* src/wtb_dpath.sv */
// Datapath of the tone burst generator: registers, counters, phase, window and scaling.
module wtb_dpath import wtb_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                sample_invalid_i,
  input  cmd_t                cmd_i,
  output sts_t                sts_o,
  output logic [OutW-1:0]     out_sample_o,
  output logic                is_muted_o,
  output logic                in_burst_o,
  output logic                burst_end_o,
  output logic [7:0]          bursts_emitted_o
);

  // Configuration registers.
  logic [23:0]     lead_q, spacing_q, watchdog_q;
  logic [15:0]     blen_q;
  logic [7:0]      bcount_q;
  logic [31:0]     tone_step_q, win_step_q;
  logic [AmpW-1:0] amp_q;

  // Control state.
  logic [31:0] frame_q;
  logic        mute_q;
  logic [7:0]  done_q;
  logic [7:0]  done_d;

  // Per-frame working registers.
  logic [31:0]     prod_q, start_q, into_q;
  logic            ge_q, inside_q, last_q;
  logic [31:0]     tphase_q, wphase_q;
  logic [RomW-1:0] smag_q, win_q;
  logic            sneg_q;
  logic [ProdW-1:0] p1_q;
  logic [MagW-1:0]  p2_q;

  logic [OutW-1:0] sample_q;
  logic            muted_out_q, inburst_out_q, bend_out_q;
  logic [7:0]      bursts_out_q;

  logic            inside_d;
  logic [32:0]     diff;
  logic [31:0]     cphase;
  logic [RomW-1:0] cmag;
  logic [RomW:0]   win_sum;
  logic [MagW:0]   rnd;
  logic [OutW-1:0] mag, mag_clamped, sample_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_q      <= 24'd14400;
      spacing_q   <= 24'd48000;
      blen_q      <= 16'd96;
      bcount_q    <= 8'd5;
      tone_step_q <= 32'd89478485;
      win_step_q  <= 32'd45210468;
      amp_q       <= 15'd2621;
      watchdog_q  <= 24'd1440000;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgLeadIn:   lead_q      <= cfg_data_i[23:0];
        CfgSpacing:  spacing_q   <= cfg_data_i[23:0];
        CfgBurstLen: blen_q      <= cfg_data_i[15:0];
        CfgBurstCnt: bcount_q    <= cfg_data_i[7:0];
        CfgToneStep: tone_step_q <= cfg_data_i;
        CfgWinStep:  win_step_q  <= cfg_data_i;
        CfgAmp:      amp_q       <= cfg_data_i[AmpW-1:0];
        CfgWatchdog: watchdog_q  <= cfg_data_i[23:0];
        default: ;
      endcase
    end
  end

  // Burst membership, decided once the offset into the current burst is known.
  assign diff     = {1'b0, frame_q} - {1'b0, start_q};
  assign inside_d = !mute_q && (done_q < bcount_q) && ge_q && (into_q < {16'd0, blen_q});
  assign sts_o.in_burst = inside_d;

  // The window is (full scale - cos) / 2, with cos taken a quarter turn ahead.
  assign cphase  = wphase_q + QuarterTurn;
  assign cmag    = sine_mag(cphase);
  assign win_sum = cphase[31] ? ({1'b0, FullScale} + {1'b0, cmag})
                              : ({1'b0, FullScale} - {1'b0, cmag});

  // Round half away from zero on the magnitude, then clamp to half scale.
  assign rnd         = {1'b0, p2_q} + RoundHalf;
  assign mag         = rnd[MagW:RoundShift];
  assign mag_clamped = (mag > Ceiling) ? Ceiling : mag;
  assign sample_d    = !inside_q ? '0 : (sneg_q ? (~mag_clamped + 16'd1) : mag_clamped);
  assign done_d      = (inside_q && last_q) ? done_q + 8'd1 : done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q <= '0;
      mute_q  <= 1'b0;
      done_q  <= '0;
    end else begin
      if (cmd_i.accept) begin
        mute_q <= mute_q | (frame_q >= {8'd0, watchdog_q}) | sample_invalid_i;
      end
      if (cmd_i.finish) begin
        done_q <= done_d;
        if (frame_q != '1) frame_q <= frame_q + 32'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) prod_q <= {24'd0, done_q} * {8'd0, spacing_q};
    if (cmd_i.start)  start_q <= {8'd0, lead_q} + prod_q;
    if (cmd_i.cmp) begin
      into_q <= diff[31:0];
      ge_q   <= !diff[32];
    end
    if (cmd_i.phase) begin
      inside_q <= inside_d;
      last_q   <= (into_q[15:0] == blen_q - 16'd1);
      tphase_q <= {16'd0, into_q[15:0]} * tone_step_q;
      wphase_q <= {16'd0, into_q[15:0]} * win_step_q;
    end
    if (cmd_i.lookup) begin
      smag_q <= sine_mag(tphase_q);
      sneg_q <= tphase_q[31];
      win_q  <= win_sum[RomW:1];
    end
    if (cmd_i.mul1) p1_q <= {{RomW{1'b0}}, smag_q} * {{RomW{1'b0}}, win_q};
    if (cmd_i.mul2) p2_q <= {{AmpW{1'b0}}, p1_q} * {{ProdW{1'b0}}, amp_q};
    if (cmd_i.finish) begin
      sample_q      <= sample_d;
      muted_out_q   <= mute_q;
      inburst_out_q <= inside_q;
      bend_out_q    <= inside_q & last_q;
      bursts_out_q  <= done_d;
    end
  end

  assign out_sample_o     = sample_q;
  assign is_muted_o       = muted_out_q;
  assign in_burst_o       = inburst_out_q;
  assign burst_end_o      = bend_out_q;
  assign bursts_emitted_o = bursts_out_q;

endmodule

/* sim/wtb_frame_checker.sv */
// Frame checker for the tone burst generator: tracks writes, predicts and compares each frame.
module wtb_frame_checker import wtb_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic                sample_invalid_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic [OutW-1:0]     out_sample_i,
  input  logic                is_muted_i,
  input  logic                in_burst_i,
  input  logic                burst_end_i,
  input  logic [7:0]          bursts_emitted_i,
  output int                  mismatches_o,
  output int                  pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint PeakCode = (longint'(1) << (SAMPLE_WIDTH - 1)) - 1;
  localparam longint HalfScaleCap = 16384;
  localparam int unsigned MagShift = 2 * SAMPLE_WIDTH - 2;

  typedef struct packed {
    logic [15:0] sample;
    logic        muted;
    logic        in_burst;
    logic        last;
    logic [7:0]  done;
  } frame_out_t;

  longint sine_table [0:SINE_TABLE_DEPTH];

  logic [23:0] lead_in;
  logic [23:0] spacing;
  logic [15:0] burst_len;
  logic [7:0]  burst_total;
  logic [31:0] tone_step;
  logic [31:0] window_step;
  logic [14:0] amplitude;
  logic [23:0] watchdog;

  logic [31:0] frame_count;
  logic        muted;
  logic [7:0]  bursts_done;

  frame_out_t predicted_frames [$];

  // Quarter-wave table from a fixed Q2.30 odd-power series, rounded to full scale.
  initial begin
    longint unsigned angle;
    longint unsigned term;
    longint unsigned code;
    longint          acc;
    for (int unsigned k = 0; k <= SINE_TABLE_DEPTH; k++) begin
      angle = (64'd1686629713 * 64'(k)) / 64'(SINE_TABLE_DEPTH);
      term  = angle;
      acc   = longint'(angle);
      for (int unsigned n = 1; n <= 7; n++) begin
        term = (((term * angle) >> 30) * angle) >> 30;
        term = term / (64'(2 * n) * 64'(2 * n + 1));
        if (n % 2 == 1) acc = acc - longint'(term);
        else acc = acc + longint'(term);
      end
      if (acc < 0) acc = 0;
      if (acc > (longint'(1) << 30)) acc = longint'(1) << 30;
      code = (64'(acc) * 64'(PeakCode) + (64'd1 << 29)) >> 30;
      if (code > 64'(PeakCode)) code = 64'(PeakCode);
      sine_table[k] = longint'(code);
    end
  end

  function automatic longint sine_at(input logic [31:0] phase);
    longint unsigned idx;
    longint          mag;
    idx = (64'(phase[29:0]) * 64'(SINE_TABLE_DEPTH)) >> 30;
    mag = phase[30] ? sine_table[SINE_TABLE_DEPTH - idx] : sine_table[idx];
    return phase[31] ? -mag : mag;
  endfunction

  function automatic frame_out_t render_frame(input logic invalid);
    logic [31:0]     frame;
    logic [31:0]     start;
    logic [31:0]     into;
    longint          tone;
    longint          cosine;
    longint          window;
    longint unsigned mag;
    frame_out_t      r;
    r = '0;
    frame = frame_count;
    if (!muted && frame >= 32'(watchdog)) muted = 1'b1;
    if (!muted && invalid) muted = 1'b1;
    if (!muted && bursts_done < burst_total) begin
      start = 32'(lead_in) + 32'(bursts_done) * 32'(spacing);
      if (frame >= start && (frame - start) < 32'(burst_len)) begin
        into       = frame - start;
        r.in_burst = 1'b1;
        tone       = sine_at(into * tone_step);
        cosine     = sine_at(into * window_step + 32'h4000_0000);
        window     = (PeakCode - cosine) >>> 1;
        mag = 64'(tone < 0 ? -tone : tone) * 64'(window) * 64'(amplitude);
        mag = (mag + (64'd1 << (MagShift - 1))) >> MagShift;
        if (mag > 64'(HalfScaleCap)) mag = 64'(HalfScaleCap);
        r.sample = 16'(tone < 0 ? -longint'(mag) : longint'(mag));
        if (into == 32'(burst_len) - 32'd1) begin
          r.last      = 1'b1;
          bursts_done = bursts_done + 8'd1;
        end
      end
    end
    if (frame_count != 32'hFFFF_FFFF) frame_count = frame_count + 32'd1;
    r.muted = muted;
    r.done  = bursts_done;
    return r;
  endfunction

  task automatic report(input string field, input longint expected, input longint actual);
    mismatches_o++;
    $display("%0t: %s expected %0d actual %0d", $time, field, expected, actual);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    frame_out_t want;
    if (!rst_ni) begin
      lead_in     = 24'd14400;
      spacing     = 24'd48000;
      burst_len   = 16'd96;
      burst_total = 8'd5;
      tone_step   = 32'd89478485;
      window_step = 32'd45210468;
      amplitude   = 15'd2621;
      watchdog    = 24'd1440000;
      frame_count = '0;
      muted       = 1'b0;
      bursts_done = '0;
      predicted_frames.delete();
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CfgLeadIn:   lead_in = cfg_data_i[23:0];
          CfgSpacing:  spacing = cfg_data_i[23:0];
          CfgBurstLen: burst_len = cfg_data_i[15:0];
          CfgBurstCnt: burst_total = cfg_data_i[7:0];
          CfgToneStep: tone_step = cfg_data_i;
          CfgWinStep:  window_step = cfg_data_i;
          CfgAmp:      amplitude = cfg_data_i[14:0];
          CfgWatchdog: watchdog = cfg_data_i[23:0];
          default: ;
        endcase
      end
      // Outputs are matched before this edge's input is predicted, so a result
      // can never pair with the frame accepted on the same edge.
      if (out_valid_i && out_ready_i) begin
        if (predicted_frames.size() == 0) begin
          mismatches_o++;
          $display("%0t: output transfer with no frame pending", $time);
        end else begin
          want = predicted_frames.pop_front();
          if (out_sample_i !== want.sample)
            report("out_sample", longint'($signed(want.sample)), longint'($signed(out_sample_i)));
          if (is_muted_i !== want.muted) report("is_muted", want.muted, is_muted_i);
          if (in_burst_i !== want.in_burst) report("in_burst", want.in_burst, in_burst_i);
          if (burst_end_i !== want.last) report("burst_end", want.last, burst_end_i);
          if (bursts_emitted_i !== want.done)
            report("bursts_emitted", want.done, bursts_emitted_i);
        end
      end
      if (in_valid_i && in_ready_i) predicted_frames.push_back(render_frame(sample_invalid_i));
      pending_o = predicted_frames.size();
    end
  end

endmodule

/* sim/tb_windowed_tone_burst_generator.sv */
// Testbench top for the tone burst generator: drives frames and register writes, gives the verdict.
module tb_windowed_tone_burst_generator;
  timeunit 1ns;
  timeprecision 1ps;
  import wtb_pkg::*;

  localparam int RandomFrames = 1900;
  localparam int CycleLimit   = 400000;
  localparam int MaxGap       = 12;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                sample_invalid = 1'b0;
  logic                out_ready = 1'b0;
  logic                in_ready;
  logic                out_valid;
  logic [OutW-1:0]     out_sample;
  logic                is_muted;
  logic                in_burst;
  logic                burst_end;
  logic [7:0]          bursts_emitted;

  int       mismatches;
  int       pending;
  int       frames_sent = 0;
  int       cycle_count = 0;
  logic [7:0] bursts_seen = '0;
  bit       quiet = 1'b0;

  windowed_tone_burst_generator i_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .sample_invalid_i (sample_invalid),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .out_sample_o     (out_sample),
    .is_muted_o       (is_muted),
    .in_burst_o       (in_burst),
    .burst_end_o      (burst_end),
    .bursts_emitted_o (bursts_emitted)
  );

  wtb_frame_checker i_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .sample_invalid_i (sample_invalid),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .out_sample_i     (out_sample),
    .is_muted_i       (is_muted),
    .in_burst_i       (in_burst),
    .burst_end_i      (burst_end),
    .bursts_emitted_i (bursts_emitted),
    .mismatches_o     (mismatches),
    .pending_o        (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("windowed_tone_burst_generator test failed");
      $finish;
    end
  end

  // Burst start times depend on how many bursts are done, so follow the count.
  always @(posedge clk) begin
    if (out_valid && out_ready) bursts_seen <= bursts_emitted;
  end

  initial begin
    int unsigned stall;
    forever begin
      stall = quiet ? 0 : $urandom_range(0, MaxGap);
      @(negedge clk);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic push_frame(input logic invalid);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, MaxGap);
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    sample_invalid <= invalid;
    do @(posedge clk); while (!in_ready);
    frames_sent++;
  endtask

  task automatic run_frames(input int n);
    repeat (n) push_frame(1'b0);
  endtask

  task automatic await_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending == 0);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
  endtask

  task automatic end_writes();
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_all(input logic [23:0] lead, input logic [23:0] sp,
                           input logic [15:0] len, input logic [7:0] count,
                           input logic [31:0] tone, input logic [31:0] win,
                           input logic [14:0] amp, input logic [23:0] wd);
    write_reg(CfgLeadIn, 32'(lead));
    write_reg(CfgSpacing, 32'(sp));
    write_reg(CfgBurstLen, 32'(len));
    write_reg(CfgBurstCnt, 32'(count));
    write_reg(CfgToneStep, tone);
    write_reg(CfgWinStep, win);
    write_reg(CfgAmp, 32'(amp));
    write_reg(CfgWatchdog, 32'(wd));
    end_writes();
  endtask

  // Lead-in that puts the next burst start the given number of frames ahead.
  function automatic logic [23:0] lead_for(input int unsigned delay, input logic [23:0] sp);
    longint want;
    longint used;
    want = longint'(frames_sent) + longint'(delay);
    used = longint'(bursts_seen) * longint'(sp);
    return (want >= used) ? 24'(want - used) : 24'd0;
  endfunction

  initial begin
    int          random_sent;
    int          n;
    int          delay;
    int          trigger;
    int unsigned pick;
    logic [15:0] len;
    logic [23:0] sp;
    logic [23:0] lead;
    logic [23:0] wd;
    logic [7:0]  count;
    logic [31:0] tone;
    logic [31:0] win;
    logic [14:0] amp;
    logic        invalid;
    bit          by_watchdog;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Register values straight out of reset: the lead-in keeps these frames silent.
    quiet = 1'b1;
    run_frames(3);

    // Quarter-turn tone at full amplitude hits the clamp inside a Hann window.
    await_idle();
    write_all(lead_for(1, 24'd8), 24'd8, 16'd6, bursts_seen + 8'd1, 32'h4000_0000,
              32'(64'h1_0000_0000 / 5), 15'h7FFF, 24'hFF_FFFF);
    run_frames(7);

    // One-frame bursts, each its own last frame, back to back.
    await_idle();
    quiet = 1'b0;
    write_all(lead_for(0, 24'd1), 24'd1, 16'd1, bursts_seen + 8'd3, 32'hFFFF_FFFF, 32'd0,
              15'd12000, 24'hFF_FFFF);
    run_frames(4);

    // Zero-length bursts never play, even with the burst limit at its top.
    await_idle();
    write_all(lead_for(0, 24'hFF_FFFF), 24'hFF_FFFF, 16'd0, 8'd255, 32'd0, 32'hFFFF_FFFF,
              15'd0, 24'hFF_FFFF);
    run_frames(2);

    // With no spacing all bursts share one start, so only the first plays.
    await_idle();
    write_all(lead_for(1, 24'd0), 24'd0, 16'd3, bursts_seen + 8'd3, 32'h1234_5678,
              32'h8000_0000, 15'd20000, 24'hFF_FFFF);
    run_frames(5);

    // A start time long gone is skipped for good.
    await_idle();
    write_all(24'd0, 24'd1, 16'd2, bursts_seen + 8'd2, 32'h0800_0000, 32'hFFFF_FFFF,
              15'd30000, 24'hFF_FFFF);
    run_frames(2);

    // Furthest lead-in with a zero burst limit.
    await_idle();
    write_all(24'hFF_FFFF, 24'd1, 16'hFFFF, 8'd0, 32'h0100_0000, 32'd65537, 15'd1, 24'hFF_FFFF);
    run_frames(2);

    random_sent = 0;
    while (random_sent < RandomFrames) begin
      await_idle();
      quiet = ($urandom_range(0, 3) == 0);
      len = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(25, 300))
                                        : 16'($urandom_range(2, 24));
      if ($urandom_range(0, 5) == 0) sp = 24'($urandom_range(1, len));
      else sp = 24'(len + $urandom_range(0, 16));
      delay = $urandom_range(0, 10);
      if (bursts_seen != 0 && sp > (frames_sent + delay) / bursts_seen)
        sp = 24'((frames_sent + delay) / bursts_seen);
      count = (bursts_seen > 8'd249) ? bursts_seen : bursts_seen + 8'($urandom_range(0, 6));
      pick = $urandom_range(0, 7);
      tone = (pick == 0) ? 32'd0 : (pick == 1) ? 32'hFFFF_FFFF : $urandom;
      win = ($urandom_range(0, 3) != 0) ? 32'(64'h1_0000_0000 / (len - 16'd1)) : $urandom;
      pick = $urandom_range(0, 7);
      amp = (pick == 0) ? 15'h7FFF : (pick == 1) ? 15'd0 : 15'($urandom_range(0, 32767));
      wd = ($urandom_range(0, 7) == 0) ? 24'hFF_FFFF
                                       : 24'($urandom_range(frames_sent + 100, 24'hFF_FFFF));
      pick = $urandom_range(0, 19);
      lead = (pick == 0) ? 24'd0 : (pick == 1) ? 24'hFF_FFFF : lead_for(delay, sp);
      write_all(lead, sp, len, count, tone, win, amp, wd);
      n = $urandom_range(20, 80);
      run_frames(n);
      random_sent += n;
    end

    // Muting is permanent, so it comes last: by the watchdog or by an invalid sample.
    await_idle();
    quiet = 1'b0;
    by_watchdog = $urandom_range(0, 1);
    trigger = $urandom_range(1, 12);
    wd = by_watchdog ? 24'(frames_sent + trigger) : 24'hFF_FFFF;
    count = bursts_seen + 8'($urandom_range(0, 2));
    write_all(lead_for(2, 24'd1), 24'd1, 16'd4, count, $urandom, 32'(64'h1_0000_0000 / 3),
              15'($urandom_range(0, 32767)), wd);
    for (int i = 0; i < 30; i++) begin
      if (by_watchdog) invalid = (frames_sent >= wd) && ($urandom_range(0, 1) == 1);
      else invalid = (i == trigger) || (i > trigger && $urandom_range(0, 1) == 1);
      push_frame(invalid);
    end

    // A zero watchdog limit mutes on the first frame it sees.
    await_idle();
    write_reg(CfgWatchdog, 32'd0);
    end_writes();
    repeat (5) push_frame(1'($urandom_range(0, 1)));

    await_idle();
    repeat (16) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("windowed_tone_burst_generator test passed");
    end else begin
      $display("windowed_tone_burst_generator test failed");
    end
    $finish;
  end

endmodule
